// ----- rtl/core/ntp_pkg.sv -----
// shared constants, command and status types for the nearest missing tile picker
package ntp_pkg;

    localparam int MAX_TILES_DEF = 256;

    // signed width for pixel coordinates, viewport edges and distances
    localparam int CW = 20;

    localparam logic [2:0] KIND_MARK_CACHED  = 3'd0;
    localparam logic [2:0] KIND_MARK_EVICTED = 3'd1;
    localparam logic [2:0] KIND_CLEAR_ALL    = 3'd2;
    localparam logic [2:0] KIND_PICK_NEXT    = 3'd3;
    localparam logic [2:0] KIND_LOCATE       = 3'd4;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_TILE_HEIGHT  = 2'd3;

    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic scan_step;
        logic mark_rd;
        logic mark_wr;
        logic publish;
    } ntp_cmd_t;

    typedef struct packed {
        logic in_is_mark;
        logic in_is_clear;
        logic in_is_scan;
        logic sweep_last;
        logic scan_live;
        logic out_busy;
    } ntp_sts_t;

endpackage

// ----- rtl/core/ntp_ram.sv -----
// generic single-port ram with registered read
module ntp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/ntp_ctrl.sv -----
// sequencer for clearing sweeps, marks, tile scans and result hand-off
module ntp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntp_pkg::ntp_sts_t sts,
    output ntp_pkg::ntp_cmd_t cmd
);
    import ntp_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SWEEP,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FINISH;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.in_is_mark)
                    begin
                        state_next = ST_MARK_RD;
                    end
                    else if (sts.in_is_clear)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (sts.in_is_scan)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (!sts.scan_live)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/ntp_dp.sv -----
// datapath: configuration, item registers, tile walker, cached bit store, result register
module ntp_dp #(
    parameter int MAX_TILES = ntp_pkg::MAX_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ntp_pkg::ntp_cmd_t  cmd,
    output ntp_pkg::ntp_sts_t  sts,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic [2:0]         kind,
    input  logic [7:0]         tile_number,
    input  logic signed [15:0] view_left,
    input  logic signed [15:0] view_top,
    input  logic [14:0]        view_width,
    input  logic [14:0]        view_height,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         chosen_tile,
    output logic               found,
    output logic [8:0]         cached_total
);
    import ntp_pkg::*;

    localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TILES - 1);

    // configuration
    logic [14:0] img_w_reg, img_h_reg, tile_w_reg, tile_h_reg;
    logic [14:0] tw, th;

    assign cfg_ready = 1'b1;
    assign tw = (tile_w_reg == '0) ? 15'd1 : tile_w_reg;
    assign th = (tile_h_reg == '0) ? 15'd1 : tile_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= 15'd1024;
            img_h_reg  <= 15'd1024;
            tile_w_reg <= 15'd128;
            tile_h_reg <= 15'd128;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: img_h_reg  <= cfg_data;
                REG_TILE_WIDTH:   tile_w_reg <= cfg_data;
                REG_TILE_HEIGHT:  tile_h_reg <= cfg_data;
                default:          img_w_reg  <= img_w_reg;
            endcase
        end
    end

    // input decode for the sequencer
    assign sts.in_is_mark  = (kind == KIND_MARK_CACHED) || (kind == KIND_MARK_EVICTED);
    assign sts.in_is_clear = (kind == KIND_CLEAR_ALL);
    assign sts.in_is_scan  = (kind == KIND_PICK_NEXT) || (kind == KIND_LOCATE);

    // item registers, viewport centre worked out at capture
    logic [2:0]           kind_reg;
    logic [7:0]           tnum_reg;
    logic signed [CW-1:0] vl_reg, vt_reg, vr_reg, vb_reg, cx_reg, cy_reg, px_reg, py_reg;
    logic                 view_ok_reg;
    logic signed [CW-1:0] vl_in, vt_in, sx, sy, cx_in, cy_in;

    assign vl_in = CW'(view_left);
    assign vt_in = CW'(view_top);
    assign sx    = CW'(2 * vl_in + $signed(CW'(view_width)) - 1);
    assign sy    = CW'(2 * vt_in + $signed(CW'(view_height)) - 1);
    // halve with truncation toward zero
    assign cx_in = (sx >= 0) ? (sx >>> 1) : -((-sx) >>> 1);
    assign cy_in = (sy >= 0) ? (sy >>> 1) : -((-sy) >>> 1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= kind;
            tnum_reg    <= tile_number;
            vl_reg      <= vl_in;
            vt_reg      <= vt_in;
            vr_reg      <= vl_in + $signed(CW'(view_width));
            vb_reg      <= vt_in + $signed(CW'(view_height));
            cx_reg      <= cx_in;
            cy_reg      <= cy_in;
            px_reg      <= CW'(point_x);
            py_reg      <= CW'(point_y);
            view_ok_reg <= (view_width != '0) && (view_height != '0);
        end
    end

    // tile walker, stage a: geometry of tile a_t
    logic [IW-1:0] a_t_reg;
    logic [16:0]   a_x0_reg, a_y0_reg;
    logic          a_live_reg;
    logic [16:0]   sum_x, sum_y, x1, y1, img_w17, img_h17;
    logic signed [CW-1:0] x0s, y0s, x1s, y1s, sxs, sys, gap_x, gap_y;
    logic          meets, in_pt, a_hit, wrap, a_end;

    assign img_w17 = 17'(img_w_reg);
    assign img_h17 = 17'(img_h_reg);
    assign sum_x   = a_x0_reg + 17'(tw);
    assign sum_y   = a_y0_reg + 17'(th);
    assign x1      = (sum_x > img_w17) ? img_w17 : sum_x;
    assign y1      = (sum_y > img_h17) ? img_h17 : sum_y;
    assign x0s     = $signed(CW'(a_x0_reg));
    assign y0s     = $signed(CW'(a_y0_reg));
    assign x1s     = $signed(CW'(x1));
    assign y1s     = $signed(CW'(y1));
    assign sxs     = $signed(CW'(sum_x));
    assign sys     = $signed(CW'(sum_y));

    assign gap_x = (cx_reg < x0s) ? (x0s - cx_reg) :
                   (cx_reg > x1s - CW'(1)) ? (cx_reg - x1s + CW'(1)) : '0;
    assign gap_y = (cy_reg < y0s) ? (y0s - cy_reg) :
                   (cy_reg > y1s - CW'(1)) ? (cy_reg - y1s + CW'(1)) : '0;

    assign meets = view_ok_reg && (x0s < vr_reg) && (vl_reg < x1s)
                   && (y0s < vb_reg) && (vt_reg < y1s);
    assign in_pt = (px_reg >= x0s) && (px_reg < sxs) && (py_reg >= y0s) && (py_reg < sys)
                   && (px_reg < $signed(CW'(img_w_reg))) && (py_reg < $signed(CW'(img_h_reg)));
    assign a_hit = (kind_reg == KIND_LOCATE) ? in_pt : meets;

    assign wrap  = (sum_x >= img_w17);
    assign a_end = (a_t_reg == LAST_IDX) || (wrap && (sum_y >= img_h17));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_live_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            a_live_reg <= (img_w_reg != '0) && (img_h_reg != '0);
        end
        else if (cmd.scan_step && a_end)
        begin
            a_live_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_t_reg  <= '0;
            a_x0_reg <= '0;
            a_y0_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            a_t_reg <= a_t_reg + 1'b1;
            if (wrap)
            begin
                a_x0_reg <= '0;
                a_y0_reg <= sum_y;
            end
            else
            begin
                a_x0_reg <= sum_x;
            end
        end
    end

    assign sts.scan_live = a_live_reg;

    // stage b: candidate meets the cached bit read from the store
    logic                 b_valid_reg, b_hit_reg;
    logic [IW-1:0]        b_t_reg;
    logic signed [CW-1:0] b_dist_reg;
    logic                 best_found_reg;
    logic [IW-1:0]        best_t_reg;
    logic signed [CW-1:0] best_dist_reg;
    logic                 bit_rd;
    logic                 cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= cmd.scan_step && a_live_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_t_reg    <= a_t_reg;
        b_hit_reg  <= a_hit;
        b_dist_reg <= gap_x + gap_y;
    end

    // a locate ignores the cached bit; its single match wins
    assign cand = b_valid_reg && b_hit_reg && ((kind_reg == KIND_LOCATE) || !bit_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            best_found_reg <= 1'b0;
        end
        else if (cand && (!best_found_reg || (b_dist_reg < best_dist_reg)))
        begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            best_t_reg    <= '0;
            best_dist_reg <= '0;
        end
        else if (cand && (!best_found_reg || (b_dist_reg < best_dist_reg)))
        begin
            best_t_reg    <= b_t_reg;
            best_dist_reg <= b_dist_reg;
        end
    end

    // cached bit store: clearing sweep, marks and scan reads share one port
    logic [IW-1:0] sweep_reg;
    logic [IW-1:0] mem_addr;
    logic          mem_we, mem_wdata;
    logic          want, in_range;
    logic [8:0]    cnt_reg;

    assign sts.sweep_last = (sweep_reg == LAST_IDX);
    assign want     = (kind_reg == KIND_MARK_CACHED);
    assign in_range = (32'(tnum_reg) < MAX_TILES);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = a_t_reg;
        if (cmd.sweep_step)
        begin
            mem_we   = 1'b1;
            mem_addr = sweep_reg;
        end
        else if (cmd.mark_rd || cmd.mark_wr)
        begin
            mem_addr  = IW'(32'(tnum_reg));
            mem_we    = cmd.mark_wr && in_range && (bit_rd != want);
            mem_wdata = want;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.sweep_step)
            begin
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + 1'b1;
                if (sts.sweep_last)
                begin
                    cnt_reg <= '0;
                end
            end
            else if (cmd.mark_wr && in_range && (bit_rd != want))
            begin
                cnt_reg <= want ? cnt_reg + 9'd1 : cnt_reg - 9'd1;
            end
        end
    end

    ntp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_TILES)
    ) u_bits (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (bit_rd)
    );

    // result register
    logic       out_valid_reg, found_reg;
    logic [7:0] chosen_reg;
    logic [8:0] total_reg;

    assign sts.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            chosen_reg <= 8'(32'(best_t_reg));
            found_reg  <= best_found_reg;
            total_reg  <= cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_tile  = chosen_reg;
    assign found        = found_reg;
    assign cached_total = total_reg;

endmodule

// ----- rtl/core/nearest_missing_tile_picker.sv -----
// top level of the nearest missing tile picker
//
// channels: in (kind plus operands), out (chosen_tile, found, cached_total) and
// cfg (cfg_index, cfg_data), each with valid/ready; a transfer happens when both
// are high at a rising clock edge. cfg_ready is always high.
// every input item gives exactly one result.
// a mark reads and then writes the cached bit, clear all sweeps every entry of
// the cached bit ram, pick and locate walk the tiles, and an unused kind goes
// straight to the result; the tile walker visits one tile per cycle and the
// single port of the cached bit ram sets that pace.
// one item is processed at a time; in_ready is high only while idle.
// a finished result waits in the output register, and the next item is taken
// meanwhile; it holds its own result until the output register is free.
// after reset the block sweeps the cached bit ram to zero with in_ready low;
// configuration falls back to a 1024 x 1024 image with 128 x 128 tiles.
module nearest_missing_tile_picker #(
    parameter int MAX_TILES = ntp_pkg::MAX_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [7:0]         tile_number,
    input  logic signed [15:0] view_left,
    input  logic signed [15:0] view_top,
    input  logic [14:0]        view_width,
    input  logic [14:0]        view_height,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         chosen_tile,
    output logic               found,
    output logic [8:0]         cached_total
);
    import ntp_pkg::*;

    ntp_cmd_t cmd;
    ntp_sts_t sts;

    ntp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ntp_dp #(
        .MAX_TILES (MAX_TILES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .tile_number  (tile_number),
        .view_left    (view_left),
        .view_top     (view_top),
        .view_width   (view_width),
        .view_height  (view_height),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chosen_tile  (chosen_tile),
        .found        (found),
        .cached_total (cached_total)
    );

endmodule

// ----- rtl/core/ntp_checker.sv -----
// port-level assertions for the nearest missing tile picker, bound to the top level
module ntp_checker #(
    parameter int MAX_TILES = ntp_pkg::MAX_TILES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] chosen_tile,
    input logic       found,
    input logic [8:0] cached_total
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_tile)
            && $stable(found) && $stable(cached_total))
        else $error("stalled result changed");

    // nothing found shows tile zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> chosen_tile == 8'd0)
        else $error("chosen_tile nonzero without found");

    // one item at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // count never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MAX_TILES > 511) || (32'(cached_total) <= MAX_TILES))
        else $error("cached_total beyond tile store");

endmodule

bind nearest_missing_tile_picker ntp_checker #(
    .MAX_TILES (MAX_TILES)
) u_ntp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chosen_tile  (chosen_tile),
    .found        (found),
    .cached_total (cached_total)
);
